// ===== sv/lwd_pkg.sv =====
// Shared types and constants for the LZSS window decompressor.
package lwd_pkg;

    localparam int WIN_AW = 12;
    localparam logic [WIN_AW-1:0] WIN_START = 12'd4078;
    localparam logic [WIN_AW:0] WIN_FULL = 13'd4096;
    localparam logic [7:0] WIN_FILL_BYTE = 8'h20;
    localparam logic [4:0] LEN_BIAS = 5'd3;
    localparam int LWD_QUEUE_DEPTH = 4;

    localparam logic REG_OUTPUT_LENGTH = 1'b0;

    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_LIT = 2'd1;
    localparam logic [1:0] CMD_REF = 2'd2;

    typedef struct packed {
        logic              restart;
        logic [1:0]        kind;
        logic [7:0]        data;
        logic [WIN_AW-1:0] pos;
        logic [4:0]        len;
    } cmd_t;

endpackage

// ===== sv/lwd_front.sv =====
// Front end: parses flag, literal and reference bytes into commands.
module lwd_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_in_byte,
    input  logic          s_start_stream,
    input  logic          q_full,
    output logic          push_valid,
    output lwd_pkg::cmd_t push_cmd
);
    import lwd_pkg::*;

    localparam logic [1:0] PH_TOKEN = 2'd0;
    localparam logic [1:0] PH_FLAG = 2'd1;
    localparam logic [1:0] PH_HELD = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [15:0] flag_reg, flag_next;
    logic [7:0]  held_reg, held_next;
    logic [1:0]  ph;
    logic [15:0] fs;
    logic        accept;

    assign s_ready = !q_full;
    assign accept = s_valid && s_ready;

    always_comb begin
        ph = s_start_stream ? PH_TOKEN : phase_reg;
        fs = s_start_stream ? 16'd0 : flag_reg;
        phase_next = ph;
        flag_next = fs;
        held_next = s_start_stream ? 8'd0 : held_reg;
        push_cmd.restart = s_start_stream;
        push_cmd.kind = CMD_NONE;
        push_cmd.data = s_in_byte;
        push_cmd.pos = {s_in_byte[7:4], held_reg};
        push_cmd.len = {1'b0, s_in_byte[3:0]} + LEN_BIAS;
        case (ph)
            PH_HELD: begin
                push_cmd.kind = CMD_REF;
                phase_next = PH_TOKEN;
            end
            default: begin
                if (ph != PH_FLAG) begin
                    flag_next = {1'b0, fs[15:1]};
                end
                if (ph != PH_FLAG && !flag_next[8]) begin
                    flag_next = {8'hFF, s_in_byte};
                    phase_next = PH_FLAG;
                end else if (flag_next[0]) begin
                    push_cmd.kind = CMD_LIT;
                    phase_next = PH_TOKEN;
                end else begin
                    held_next = s_in_byte;
                    phase_next = PH_HELD;
                end
            end
        endcase
        push_valid = accept && (push_cmd.restart || push_cmd.kind != CMD_NONE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TOKEN;
            flag_reg <= 16'd0;
            held_reg <= 8'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            flag_reg <= flag_next;
            held_reg <= held_next;
        end
    end

endmodule

// ===== sv/lwd_queue.sv =====
// Command queue between the parser and the window engine.
module lwd_queue #(
    parameter int DEPTH = lwd_pkg::LWD_QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  lwd_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output lwd_pkg::cmd_t head_cmd
);
    import lwd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/lwd_back.sv =====
// Back end: history window, reference copy engine and output register.
module lwd_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    input  lwd_pkg::cmd_t cmd,
    output logic          pop,
    input  logic [31:0]   cfg_length,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_byte,
    output logic          m_run_last,
    output logic          m_stream_done
);
    import lwd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [7:0]        win_mem [1 << WIN_AW];
    logic [1:0]        state_reg, state_next;
    logic [31:0]       rem_reg, rem_next;
    logic              fin_reg, fin_next;
    logic [WIN_AW-1:0] wpos_reg, wpos_next;
    logic [WIN_AW:0]   fill_reg, fill_next;
    logic [WIN_AW-1:0] pos_reg, pos_next;
    logic [4:0]        len_reg, len_next;
    logic [7:0]        rd_q_reg;
    logic              rd_hit_reg;
    logic [WIN_AW-1:0] rd_off;
    logic              rd_en;
    logic              wr_en;
    logic [WIN_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              emit_en, emit_last, emit_done;
    logic [7:0]        emit_byte;
    logic              out_free;
    logic              m_valid_reg;
    logic [7:0]        m_byte_reg;
    logic              m_last_reg, m_done_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign rd_off = pos_reg - WIN_START;

    always_comb begin
        state_next = state_reg;
        rem_next = rem_reg;
        fin_next = fin_reg;
        wpos_next = wpos_reg;
        fill_next = fill_reg;
        pos_next = pos_reg;
        len_next = len_reg;
        pop = 1'b0;
        rd_en = 1'b0;
        emit_en = 1'b0;
        emit_byte = cmd.data;
        emit_last = 1'b0;
        emit_done = 1'b0;
        wr_en = 1'b0;
        wr_addr = wpos_reg;
        wr_data = cmd.data;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.restart) begin
                        rem_next = cfg_length;
                        fin_next = (cfg_length == 32'd0);
                        wpos_next = WIN_START;
                        fill_next = '0;
                    end
                    if (fin_next || cmd.kind == CMD_NONE) begin
                        pop = 1'b1;
                    end else if (cmd.kind == CMD_LIT) begin
                        if (out_free) begin
                            pop = 1'b1;
                            emit_en = 1'b1;
                            emit_byte = cmd.data;
                            emit_last = 1'b1;
                        end
                    end else begin
                        pop = 1'b1;
                        pos_next = cmd.pos;
                        len_next = cmd.len;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                rd_en = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (out_free) begin
                    emit_en = 1'b1;
                    emit_byte = rd_hit_reg ? rd_q_reg : WIN_FILL_BYTE;
                    emit_last = (len_reg == 5'd1);
                    pos_next = pos_reg + 1'b1;
                    len_next = len_reg - 1'b1;
                    state_next = ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (emit_en) begin
            emit_done = (rem_next == 32'd1);
            rem_next = rem_next - 32'd1;
            if (emit_done) begin
                fin_next = 1'b1;
            end else begin
                wr_en = 1'b1;
                wr_addr = wpos_next;
                wr_data = emit_byte;
                wpos_next = wpos_next + 1'b1;
                if (fill_next != WIN_FULL) begin
                    fill_next = fill_next + 1'b1;
                end
            end
            if (emit_done || emit_last) begin
                emit_last = 1'b1;
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            win_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg <= win_mem[pos_reg];
            rd_hit_reg <= ({1'b0, rd_off} < fill_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rem_reg <= 32'd1;
            fin_reg <= 1'b0;
            wpos_reg <= WIN_START;
            fill_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rem_reg <= rem_next;
            fin_reg <= fin_next;
            wpos_reg <= wpos_next;
            fill_reg <= fill_next;
            if (emit_en) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        len_reg <= len_next;
        if (emit_en) begin
            m_byte_reg <= emit_byte;
            m_last_reg <= emit_last;
            m_done_reg <= emit_done;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_run_last = m_last_reg;
    assign m_stream_done = m_done_reg;

endmodule

// ===== sv/lzss_window_decompressor_top.sv =====
// LZSS decompressor with a 4096-byte history window, top level.
// Input channel (s_valid/s_ready): one compressed byte per transfer, with
// s_start_stream set on the first byte of a new stream. Result channel
// (m_valid/m_ready): one decompressed byte per transfer; m_run_last marks the
// last byte caused by one input byte, m_stream_done the byte that completes
// the output_length written over the APB port (register 0, byte address 0).
// A parser accepts one byte per cycle into a command queue while it has room;
// flag bytes and first reference bytes produce no output. The window engine
// emits a literal as it takes the command; for a reference it takes the
// command, then for each copied byte reads the window and then emits the byte
// and writes it back. Either way it waits while the output register holds a
// byte not yet taken. A literal passes through the queue and the output
// register; a reference byte also passes through the window read register.
// Reset and stream start set the window to spaces at once through a fill
// count; no clearing pass is needed. Once the stream is done, input bytes are
// taken and dropped until a new stream starts. When the receiver stalls, the
// output register holds its byte, the engine waits and the queue fills, after
// which s_ready drops.
module lzss_window_decompressor_top #(
    parameter int QUEUE_DEPTH = lwd_pkg::LWD_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_start_stream,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_run_last,
    output logic        m_stream_done,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lwd_pkg::*;

    logic [31:0] length_reg;
    logic        push_valid, q_full, q_not_empty, q_pop;
    cmd_t        push_cmd, head_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_OUTPUT_LENGTH) ? length_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg <= 32'd1;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_OUTPUT_LENGTH) begin
            length_reg <= pwdata;
        end
    end

    lwd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_start_stream(s_start_stream),
        .q_full        (q_full),
        .push_valid    (push_valid),
        .push_cmd      (push_cmd)
    );

    lwd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push_valid),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .not_empty(q_not_empty),
        .head_cmd (head_cmd)
    );

    lwd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (q_not_empty),
        .cmd          (head_cmd),
        .pop          (q_pop),
        .cfg_length   (length_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_run_last   (m_run_last),
        .m_stream_done(m_stream_done)
    );

endmodule

// ===== sv/lwd_checker.sv =====
// Port-level checks for the LZSS window decompressor, bound to the top level.
module lwd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_run_last,
    input logic       m_stream_done
);

    a_idle_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
            && $stable(m_run_last) && $stable(m_stream_done))
        else $error("stalled result changed");

    a_done_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stream_done |-> m_run_last)
        else $error("final byte not marked as end of run");

    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

endmodule

bind lzss_window_decompressor_top lwd_checker u_lwd_checker (.*);

// ===== sim/tb.sv =====
// Testbench for the LZSS window decompressor: streams, checked against a byte predictor.
`timescale 1ns / 100ps

module tb;
    import lwd_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 34;
    localparam int LONG_HOLD = 400;

    typedef enum bit [1:0] {
        PH_TOKEN        = 2'd0,
        PH_FLAGS_LOADED = 2'd1,
        PH_REF_HIGH     = 2'd2
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
    } plain_byte_t;

    class lzss_decode_sb;
        bit [7:0]     window [0:4095];
        bit [11:0]    wr_pos;
        bit [15:0]    flag_bits;
        parse_phase_t phase;
        bit [7:0]     low_hold;
        bit [31:0]    left;
        bit [31:0]    length;
        bit           done_flag;
        plain_byte_t  fresh[$];
        plain_byte_t  plain_due[$];
        int n_errors, n_checked, n_consumed, n_literals, n_refs, n_streams;

        function new();
            length = 32'd1;
            restart();
        endfunction

        function void restart();
            foreach (window[i]) window[i] = WIN_FILL_BYTE;
            wr_pos = WIN_START;
            flag_bits = 16'h0000;
            phase = PH_TOKEN;
            low_hold = 8'h00;
            left = length;
            done_flag = (length == 32'd0);
        endfunction

        function void set_length(bit [31:0] v);
            length = v;
        endfunction

        function void flag_error(string what, bit [31:0] want, bit [31:0] got);
            n_errors++;
            if (n_errors <= 10)
                $display("mismatch %s: expected %0h, got %0h", what, want, got);
        endfunction

        function bit emit_byte(bit [7:0] b);
            plain_byte_t beat;
            beat.data = b;
            beat.last = 1'b0;
            beat.done = 1'b0;
            left = left - 32'd1;
            if (left == 32'd0) begin
                beat.done = 1'b1;
                done_flag = 1'b1;
                fresh.push_back(beat);
                return 1'b1;
            end
            fresh.push_back(beat);
            window[wr_pos] = b;
            wr_pos = wr_pos + 12'd1;
            return 1'b0;
        endfunction

        function void take_code_byte(bit [7:0] b, bit st);
            bit [11:0]   pos;
            int          len;
            plain_byte_t beat;
            if (st) begin
                restart();
                n_streams++;
            end
            if (done_flag)
                return;
            n_consumed++;
            if (phase == PH_REF_HIGH) begin
                pos = {b[7:4], low_hold};
                len = int'(b[3:0]) + int'(LEN_BIAS);
                phase = PH_TOKEN;
                n_refs++;
                for (int i = 0; i < len; i++) begin
                    if (emit_byte(window[pos + 12'(i)]))
                        break;
                end
            end else begin
                if (phase != PH_FLAGS_LOADED) begin
                    flag_bits = flag_bits >> 1;
                    if (!flag_bits[8]) begin
                        flag_bits = 16'hFF00 | {8'h00, b};
                        phase = PH_FLAGS_LOADED;
                        return;
                    end
                end
                if (flag_bits[0]) begin
                    phase = PH_TOKEN;
                    n_literals++;
                    void'(emit_byte(b));
                end else begin
                    low_hold = b;
                    phase = PH_REF_HIGH;
                end
            end
            if (fresh.size() > 0) begin
                beat = fresh.pop_back();
                beat.last = 1'b1;
                fresh.push_back(beat);
            end
            while (fresh.size() > 0)
                plain_due.push_back(fresh.pop_front());
        endfunction

        function void match_plain_byte(logic [7:0] d, logic l, logic dn);
            plain_byte_t want;
            if (plain_due.size() == 0) begin
                flag_error("unexpected output byte", 32'h0, {24'h0, d});
                return;
            end
            want = plain_due.pop_front();
            n_checked++;
            if (d !== want.data)
                flag_error("out_byte", {24'h0, want.data}, {24'h0, d});
            if (l !== want.last)
                flag_error("run_last", {31'h0, want.last}, {31'h0, l});
            if (dn !== want.done)
                flag_error("stream_done", {31'h0, want.done}, {31'h0, dn});
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        s_start_stream;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_byte;
    logic        m_run_last;
    logic        m_stream_done;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lzss_decode_sb sb;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_cycles = 0;
    int quiet = 0;

    lzss_window_decompressor_top i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_start_stream (s_start_stream),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_run_last     (m_run_last),
        .m_stream_done  (m_stream_done),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hold off for a long stretch on request, else stall at random
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.match_plain_byte(m_out_byte, m_run_last, m_stream_done);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic bit [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_byte(input bit [7:0] b, input bit st);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= b;
        s_start_stream <= st;
        do @(posedge aclk); while (!s_ready);
        sb.take_code_byte(b, st);
    endtask

    task automatic send_ref();
        bit [11:0] pos;
        bit [3:0]  nib;
        if ($urandom_range(1))
            pos = sb.wr_pos - 12'($urandom_range(64, 1));
        else
            pos = 12'($urandom);
        nib = 4'($urandom);
        send_byte(pos[7:0], 1'b0);
        send_byte({pos[11:8], nib}, 1'b0);
    endtask

    task automatic play_stream();
        int       n_tok;
        int       tok;
        bit [7:0] flag_b;
        bit       first;
        n_tok = $urandom_range(40, 3);
        tok = 0;
        first = 1'b1;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(12, 3)) begin
                send_byte(8'($urandom), first);
                first = 1'b0;
            end
        end else begin
            do begin
                flag_b = pick_byte();
                send_byte(flag_b, first);
                first = 1'b0;
                for (int j = 0; j < 8 && !sb.done_flag && tok < n_tok; j++) begin
                    if (flag_b[j])
                        send_byte(pick_byte(), 1'b0);
                    else
                        send_ref();
                    tok++;
                end
            end while (!sb.done_flag && tok < n_tok);
        end
        if (sb.done_flag)
            repeat ($urandom_range(2)) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.plain_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(input bit wr, input logic [2:0] a, input logic [31:0] d,
                              output logic [31:0] rd);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= a;
        pwdata <= d;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_length(input bit [31:0] v);
        logic [31:0] rd;
        settle();
        apb_access(1'b1, {REG_OUTPUT_LENGTH, 2'b00}, v, rd);
        apb_access(1'b0, {REG_OUTPUT_LENGTH, 2'b00}, 32'h0, rd);
        if (rd !== v)
            sb.flag_error("output_length readback", v, rd);
        sb.set_length(v);
    endtask

    initial begin
        bit [31:0] len;
        int        target;
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_in_byte = 8'h00;
        s_start_stream = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'h0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset length of one, then a byte after completion
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);

        // references: full length at start, wrap, overlap; literals at extremes
        write_length(32'hFFFF_FFFF);
        send_byte(8'hAA, 1'b1);
        send_byte(8'hEE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hF1, 1'b0);
        send_byte(8'hA5, 1'b0);

        // restart mid-stream with the flag byte on the same transfer
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);

        // completion inside a reference, then a dropped byte
        write_length(32'd4);
        send_byte(8'h00, 1'b1);
        send_byte(8'hEE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);

        for (int m = 0; m < 3; m++) begin
            tx_idle_pct = (m == 0) ? 35 : (m == 1) ? 75 : 0;
            rx_idle_pct = (m == 0) ? 75 : (m == 1) ? 35 : 0;
            for (int k = 0; k < 3; k++) begin
                if (m == 0 && k == 0)
                    len = 32'd2;
                else if (m == 1 && k == 1)
                    len = 32'hFFFF_FFFF;
                else if (m == 2 && k == 2)
                    len = 32'd1;
                else
                    len = $urandom_range(200, 12);
                write_length(len);
                if (m == 2 && k == 0)
                    hold_cycles = LONG_HOLD;
                target = sb.n_consumed + ITEMS_PER_PHASE;
                while (sb.n_consumed < target)
                    play_stream();
            end
        end

        settle();
        $display("run: %0d streams, %0d compressed bytes decoded (%0d literals, %0d references)",
                 sb.n_streams, sb.n_consumed, sb.n_literals, sb.n_refs);
        $display("run: %0d output bytes checked, %0d mismatches", sb.n_checked, sb.n_errors);
        if (sb.n_errors == 0 && sb.plain_due.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/lwd_pkg.sv
sv/lwd_front.sv
sv/lwd_queue.sv
sv/lwd_back.sv
sv/lzss_window_decompressor_top.sv
sv/lwd_checker.sv
sim/tb.sv
